>>> hdl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Types and codes shared by the collision recovery sequencer.
// ----------------------------------------------------------------------------
package crs_pkg;

  // Recovery phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_HOLD = 8'b0000_0010,
    PH_STOP = 8'b0000_0100,
    PH_WREV = 8'b0000_1000,
    PH_REV  = 8'b0001_0000,
    PH_RBRK = 8'b0010_0000,
    PH_WDRV = 8'b0100_0000,
    PH_COOL = 8'b1000_0000
  } phase_e;

  localparam int unsigned PhaseCodeW = 3;
  typedef logic [PhaseCodeW-1:0] phase_code_t;

  // Command kinds
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_BRAKE   = 2'd1;
  localparam logic [1:0] CMD_REVERSE = 2'd2;

  // Gear requests
  localparam logic [1:0] GEAR_KEEP    = 2'd0;
  localparam logic [1:0] GEAR_DRIVE   = 2'd1;
  localparam logic [1:0] GEAR_REVERSE = 2'd2;

  // Reason codes
  typedef logic [4:0] reason_t;
  localparam reason_t RSN_NONE          = 5'd0;
  localparam reason_t RSN_NONSTATIC     = 5'd1;
  localparam reason_t RSN_STATIC_STOP   = 5'd2;
  localparam reason_t RSN_NONSTATIC_REM = 5'd3;
  localparam reason_t RSN_TO_NONSTATIC  = 5'd4;
  localparam reason_t RSN_STOP_PRE_REV  = 5'd5;
  localparam reason_t RSN_REAR_BLOCKED  = 5'd6;
  localparam reason_t RSN_REQ_REV       = 5'd7;
  localparam reason_t RSN_REV_CANCEL    = 5'd8;
  localparam reason_t RSN_WAIT_REV      = 5'd9;
  localparam reason_t RSN_REV_DONE      = 5'd10;
  localparam reason_t RSN_BRAKE_POST    = 5'd11;
  localparam reason_t RSN_WAIT_CLEAR    = 5'd12;
  localparam reason_t RSN_STOP_PRE_DRV  = 5'd13;
  localparam reason_t RSN_REQ_DRV       = 5'd14;
  localparam reason_t RSN_DRV_RESTORED  = 5'd15;
  localparam reason_t RSN_COOLDOWN      = 5'd16;

  // Register map (word index)
  localparam logic [2:0] REG_NEAR_STOP  = 3'd0;
  localparam logic [2:0] REG_REV_TIME   = 3'd1;
  localparam logic [2:0] REG_RBRK_TIME  = 3'd2;
  localparam logic [2:0] REG_COOL_TIME  = 3'd3;
  localparam logic [2:0] REG_REV_THR    = 3'd4;
  localparam logic [2:0] REG_DRV_GEAR   = 3'd5;
  localparam logic [2:0] REG_REV_GEAR   = 3'd6;

  localparam logic [9:0] ThrottleMax = 10'd1000;

  function automatic phase_code_t phase_code(input phase_e ph);
    phase_code_t c;
    c = '0;
    case (ph)
      PH_IDLE: c = 3'd0;
      PH_HOLD: c = 3'd1;
      PH_STOP: c = 3'd2;
      PH_WREV: c = 3'd3;
      PH_REV:  c = 3'd4;
      PH_RBRK: c = 3'd5;
      PH_WDRV: c = 3'd6;
      PH_COOL: c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/collision_recovery_sequencer.sv
// ----------------------------------------------------------------------------
// collision_recovery_sequencer
// Eight-phase brake / reverse / drive recovery after a reported collision.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one tick per beat: an
//   evaluation tick (action 0) or a halt (action 1). Output channel
//   (out_valid_o / out_ready_i) carries one result beat per evaluation tick;
//   a halt moves the phase and produces no beat.
//   An accepted tick lands in an input register and is evaluated there; its
//   result is registered in the output register that drives out_valid_o.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   limit is the single evaluation stage, which owns the phase, timer and
//   counter.
//   When the receiver stalls, the result stays in the output register, one
//   more tick waits in the input register and then in_ready_o drops. A halt
//   retires from the input register even while the output is stalled, since
//   it produces no beat.
//   Reset puts the block in idle with timer start and recovery count zero and
//   loads the register defaults. Registers are written over the APB port at
//   byte address 4*index and read back there.
// ----------------------------------------------------------------------------
module collision_recovery_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [31:0]        now_ms_i,
  input  logic               collision_present_i,
  input  logic               collision_all_static_i,
  input  logic signed [15:0] speed_i,
  input  logic [7:0]         gear_report_i,
  input  logic               rear_clear_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               running_o,
  output logic [1:0]         command_kind_o,
  output logic [9:0]         throttle_o,
  output logic [1:0]         gear_request_o,
  output logic [4:0]         reason_code_o,
  output logic [2:0]         phase_now_o,
  output logic [15:0]        recovery_total_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [14:0] near_stop_q;
  logic [15:0] rev_time_q, rbrk_time_q, cool_time_q;
  logic [9:0]  rev_thr_q;
  logic [7:0]  drv_gear_q, rev_gear_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_stop_q <= 15'd100;
      rev_time_q  <= 16'd1000;
      rbrk_time_q <= 16'd500;
      cool_time_q <= 16'd2000;
      rev_thr_q   <= 10'd200;
      drv_gear_q  <= 8'd1;
      rev_gear_q  <= 8'd2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        crs_pkg::REG_NEAR_STOP: near_stop_q <= pwdata[14:0];
        crs_pkg::REG_REV_TIME:  rev_time_q  <= pwdata[15:0];
        crs_pkg::REG_RBRK_TIME: rbrk_time_q <= pwdata[15:0];
        crs_pkg::REG_COOL_TIME: cool_time_q <= pwdata[15:0];
        crs_pkg::REG_REV_THR:   rev_thr_q   <= pwdata[9:0];
        crs_pkg::REG_DRV_GEAR:  drv_gear_q  <= pwdata[7:0];
        crs_pkg::REG_REV_GEAR:  rev_gear_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      crs_pkg::REG_NEAR_STOP: prdata = {17'd0, near_stop_q};
      crs_pkg::REG_REV_TIME:  prdata = {16'd0, rev_time_q};
      crs_pkg::REG_RBRK_TIME: prdata = {16'd0, rbrk_time_q};
      crs_pkg::REG_COOL_TIME: prdata = {16'd0, cool_time_q};
      crs_pkg::REG_REV_THR:   prdata = {22'd0, rev_thr_q};
      crs_pkg::REG_DRV_GEAR:  prdata = {24'd0, drv_gear_q};
      crs_pkg::REG_REV_GEAR:  prdata = {24'd0, rev_gear_q};
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic               iv_q;
  logic               act_q, pres_q, stat_q, rear_q;
  logic [31:0]        now_q;
  logic signed [15:0] spd_q;
  logic [7:0]         gear_q;
  logic               out_room, step;

  assign out_room   = !out_valid_o || out_ready_i;
  // halts retire without a result beat
  assign step       = iv_q && (act_q || out_room);
  assign in_ready_o = !iv_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      now_q  <= now_ms_i;
      pres_q <= collision_present_i;
      stat_q <= collision_all_static_i;
      spd_q  <= speed_i;
      gear_q <= gear_report_i;
      rear_q <= rear_clear_i;
    end
  end

  // --------------------------------------------------------------------------
  // Evaluation stage
  // --------------------------------------------------------------------------
  crs_pkg::phase_e phase_q, phase_d;
  logic [31:0]     start_q, start_d;
  logic [15:0]     cnt_q, cnt_d;

  logic        is_static, nonstatic, moving, rev_ok, drv_ok;
  logic [16:0] spd_mag;
  logic [31:0] diff;
  logic        long_wait;
  logic        restarted;
  logic        done;
  logic        r_run;
  logic [1:0]  r_kind, r_gear;
  logic [4:0]  r_reason;
  logic [9:0]  thr_sat;

  assign is_static = pres_q & stat_q;
  assign nonstatic = pres_q & ~stat_q;
  assign spd_mag   = spd_q[15] ? (17'd0 - {spd_q[15], spd_q}) : {1'b0, spd_q};
  assign moving    = spd_mag > {2'b00, near_stop_q};
  assign rev_ok    = gear_q == rev_gear_q;
  assign drv_ok    = gear_q == drv_gear_q;
  assign diff      = now_q - start_q;
  assign long_wait = |diff[31:16];
  assign thr_sat   = (rev_thr_q > crs_pkg::ThrottleMax) ? crs_pkg::ThrottleMax : rev_thr_q;

  // A phase entered in this tick has zero elapsed time.
  function automatic logic timer_done(input logic rst, input logic lw,
                                      input logic [15:0] lo, input logic [15:0] dur);
    logic r;
    r = rst ? (dur == 16'd0) : (lw || (lo >= dur));
    return r;
  endfunction

  always_comb begin
    phase_d   = phase_q;
    start_d   = start_q;
    cnt_d     = cnt_q;
    restarted = 1'b0;
    done      = 1'b0;
    r_run     = 1'b1;
    r_kind    = crs_pkg::CMD_BRAKE;
    r_gear    = crs_pkg::GEAR_KEEP;
    r_reason  = crs_pkg::RSN_NONE;

    if (act_q) begin
      done = 1'b1;
      if (phase_q != crs_pkg::PH_IDLE && phase_q != crs_pkg::PH_COOL) begin
        phase_d = crs_pkg::PH_WDRV;
        start_d = now_q;
      end
    end

    if (!done && phase_d == crs_pkg::PH_IDLE) begin
      done = 1'b1;
      if (!pres_q) begin
        r_run  = 1'b0;
        r_kind = crs_pkg::CMD_NONE;
      end else if (!is_static) begin
        phase_d  = crs_pkg::PH_HOLD;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_NONSTATIC;
      end else begin
        phase_d  = crs_pkg::PH_STOP;
        start_d  = now_q;
        cnt_d    = cnt_q + 16'd1;
        r_reason = crs_pkg::RSN_STATIC_STOP;
      end
    end

    if (!done && phase_d == crs_pkg::PH_HOLD) begin
      if (pres_q) begin
        done     = 1'b1;
        r_reason = crs_pkg::RSN_NONSTATIC_REM;
      end else begin
        phase_d   = crs_pkg::PH_WDRV;
        start_d   = now_q;
        restarted = 1'b1;
      end
    end

    if (!done && phase_d == crs_pkg::PH_STOP) begin
      done = 1'b1;
      if (nonstatic) begin
        phase_d  = crs_pkg::PH_HOLD;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_TO_NONSTATIC;
      end else if (moving) begin
        r_reason = crs_pkg::RSN_STOP_PRE_REV;
      end else if (!rear_q) begin
        r_reason = crs_pkg::RSN_REAR_BLOCKED;
      end else begin
        phase_d  = crs_pkg::PH_WREV;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_REQ_REV;
        r_gear   = crs_pkg::GEAR_REVERSE;
      end
    end

    if (!done && phase_d == crs_pkg::PH_WREV) begin
      if (nonstatic || !rear_q) begin
        done     = 1'b1;
        phase_d  = crs_pkg::PH_WDRV;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_REV_CANCEL;
      end else if (!rev_ok) begin
        done     = 1'b1;
        r_reason = crs_pkg::RSN_WAIT_REV;
        r_gear   = crs_pkg::GEAR_REVERSE;
      end else begin
        phase_d   = crs_pkg::PH_REV;
        start_d   = now_q;
        restarted = 1'b1;
      end
    end

    if (!done && phase_d == crs_pkg::PH_REV) begin
      done = 1'b1;
      if (nonstatic || !rear_q || !rev_ok) begin
        phase_d  = crs_pkg::PH_WDRV;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_REV_CANCEL;
      end else if (timer_done(restarted, long_wait, diff[15:0], rev_time_q)) begin
        phase_d  = crs_pkg::PH_RBRK;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_REV_DONE;
        r_gear   = crs_pkg::GEAR_REVERSE;
      end else begin
        r_kind = crs_pkg::CMD_REVERSE;
        r_gear = crs_pkg::GEAR_REVERSE;
      end
    end

    if (!done && phase_d == crs_pkg::PH_RBRK) begin
      if (!moving && timer_done(restarted, long_wait, diff[15:0], rbrk_time_q)) begin
        phase_d   = crs_pkg::PH_WDRV;
        start_d   = now_q;
        restarted = 1'b1;
      end else begin
        done     = 1'b1;
        r_reason = crs_pkg::RSN_BRAKE_POST;
        r_gear   = crs_pkg::GEAR_REVERSE;
      end
    end

    if (!done && phase_d == crs_pkg::PH_WDRV) begin
      done = 1'b1;
      if (pres_q) begin
        r_reason = crs_pkg::RSN_WAIT_CLEAR;
      end else if (moving) begin
        r_reason = crs_pkg::RSN_STOP_PRE_DRV;
      end else if (!drv_ok) begin
        r_reason = crs_pkg::RSN_REQ_DRV;
        r_gear   = crs_pkg::GEAR_DRIVE;
      end else begin
        phase_d  = crs_pkg::PH_COOL;
        start_d  = now_q;
        r_reason = crs_pkg::RSN_DRV_RESTORED;
      end
    end

    if (!done && phase_d == crs_pkg::PH_COOL) begin
      if (pres_q) begin
        start_d  = now_q;
        r_reason = crs_pkg::RSN_WAIT_CLEAR;
      end else if (!timer_done(restarted, long_wait, diff[15:0], cool_time_q)) begin
        r_reason = crs_pkg::RSN_COOLDOWN;
      end else begin
        phase_d = crs_pkg::PH_IDLE;
        r_run   = 1'b0;
        r_kind  = crs_pkg::CMD_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crs_pkg::PH_IDLE;
      start_q <= '0;
      cnt_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic emit;
  assign emit = step && !act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_room) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      running_o        <= r_run;
      command_kind_o   <= r_kind;
      throttle_o       <= (r_kind == crs_pkg::CMD_REVERSE) ? thr_sat : 10'd0;
      gear_request_o   <= r_gear;
      reason_code_o    <= r_reason;
      phase_now_o      <= crs_pkg::phase_code(phase_d);
      recovery_total_o <= cnt_d;
    end
  end

endmodule
